@@ sv/sfla_pkg.sv @@
// Shared types, codes and constants for the slot free-list allocator.
// No dependencies; every other file imports this package.
package sfla_pkg;

  localparam int SLOTS  = 256;
  localparam int SLOT_W = 8;            // slot index width
  localparam int LINK_W = SLOT_W + 1;   // list entry: slot index or end marker
  localparam int PAGE_W = 40;
  localparam int ORD_W  = 4;
  localparam int STR_W  = 17;           // 2^15 + 1 at most
  localparam int REM_W  = 24;           // offset inside the area, below 2^24
  localparam int CNT_W  = 3;            // one quotient bit per divide step
  localparam int PROD_W = 23;           // slot * stride, below 2^23

  localparam logic [LINK_W-1:0] END_MARK = LINK_W'(SLOTS);

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  localparam logic CFG_SLOT_ORDER = 1'b0;
  localparam logic CFG_AREA_BASE  = 1'b1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_EMPTY   = 2'd1;
  localparam logic [1:0] ST_DOUBLE  = 2'd2;
  localparam logic [1:0] ST_OUTSIDE = 2'd3;

  typedef struct packed {
    logic              action;
    logic [PAGE_W-1:0] page_address;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [SLOT_W-1:0] slot_index;
    logic [PAGE_W-1:0] slot_page;
    logic [LINK_W-1:0] free_count;
    logic              all_free;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic       load;
    logic       div_init;
    logic       div_step;
    logic       mem_rd;
    logic       rd_quot;
    logic       pop;
    logic       push;
    logic       set_err;
    logic [1:0] err_code;
    logic       out_load;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_free;
    logic head_empty;
    logic out_range;
    logic div_last;
    logic marker_hit;
  } sts_t;

  // Link value of an entry that has not been written since reset.
  function automatic logic [LINK_W-1:0] reset_link(input logic [SLOT_W-1:0] slot);
    logic [LINK_W-1:0] v;
    if (slot == '0) begin
      v = END_MARK;
    end else begin
      v = {1'b0, slot} - LINK_W'(1);
    end
    return v;
  endfunction

endpackage

@@ sv/slot_free_list_allocator.sv @@
// Slot free-list allocator, top level: sequencer plus datapath.
// Per item: alloc reads the head entry, then pops it; empty or outside-area
// go from the check straight to the result; free runs 8 one-bit divide steps
// by 2^order+1, then a list read and update. One item in flight; the next
// beat is taken the cycle after the result is parked in the output register.
// Reset is synchronous; the list reads as its reset chain at once.
module slot_free_list_allocator (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [39:0]         cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  sfla_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output sfla_pkg::out_item_t out_item
);
  import sfla_pkg::*;

  // Command and status bundles between sequencer and datapath.
  cmd_t cmd;
  sts_t sts;

  // Sequencer: idle -> check -> (divide -> read) -> (update) -> done.
  sfla_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Datapath: list memory with per-entry valid bits (unwritten entries read
  // as their reset link), head and count registers, restoring divider.
  sfla_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_item   (in_item),
    .cmd       (cmd),
    .sts       (sts),
    .out_item  (out_item)
  );

`ifndef SYNTHESIS
  // One item at a time: an accepted beat blocks the input next cycle.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while an item is in flight");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_item.free_count <= LINK_W'(SLOTS)))
    else $error("free count above slot total");

  a_all_free: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_item.all_free == (out_item.free_count == LINK_W'(SLOTS))))
    else $error("all_free disagrees with free count");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_item.status != ST_OK) |->
      (out_item.slot_index == '0) && (out_item.slot_page == '0))
    else $error("failed beat carries slot or page");
`endif

endmodule

@@ sv/sfla_ctrl.sv @@
// Sequencer for the slot free-list allocator: one item at a time.
// Depends on sfla_pkg (cmd_t, sts_t, status codes).
module sfla_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  input  sfla_pkg::sts_t sts,
  output sfla_pkg::cmd_t cmd
);
  import sfla_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE      = 7'b0000001,
    S_CHECK     = 7'b0000010,
    S_ALLOC_UPD = 7'b0000100,
    S_DIV       = 7'b0001000,
    S_FREE_RD   = 7'b0010000,
    S_FREE_UPD  = 7'b0100000,
    S_DONE      = 7'b1000000
  } state_t;

  state_t state, state_next;
  logic   out_free;

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (!sts.is_free) begin
          if (sts.head_empty) begin
            cmd.set_err  = 1'b1;
            cmd.err_code = ST_EMPTY;
            state_next   = S_DONE;
          end else begin
            cmd.mem_rd = 1'b1;
            state_next = S_ALLOC_UPD;
          end
        end else if (sts.out_range) begin
          cmd.set_err  = 1'b1;
          cmd.err_code = ST_OUTSIDE;
          state_next   = S_DONE;
        end else begin
          cmd.div_init = 1'b1;
          state_next   = S_DIV;
        end
      end
      S_ALLOC_UPD: begin
        cmd.pop    = 1'b1;
        state_next = S_DONE;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_next = S_FREE_RD;
        end
      end
      S_FREE_RD: begin
        cmd.mem_rd  = 1'b1;
        cmd.rd_quot = 1'b1;
        state_next  = S_FREE_UPD;
      end
      S_FREE_UPD: begin
        if (sts.marker_hit) begin
          cmd.push = 1'b1;
        end else begin
          cmd.set_err  = 1'b1;
          cmd.err_code = ST_DOUBLE;
        end
        state_next = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ sv/sfla_dp.sv @@
// Datapath of the slot free-list allocator: config, list memory, divider,
// counters and the output register. Depends on sfla_pkg.
module sfla_dp (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [39:0]         cfg_data,
  input  sfla_pkg::in_item_t  in_item,
  input  sfla_pkg::cmd_t      cmd,
  output sfla_pkg::sts_t      sts,
  output sfla_pkg::out_item_t out_item
);
  import sfla_pkg::*;

  logic [ORD_W-1:0]  slot_order;
  logic [PAGE_W-1:0] area_base_page;

  logic              op;
  logic [PAGE_W-1:0] addr;
  logic [LINK_W-1:0] head_link;
  logic [LINK_W-1:0] free_slots;

  logic [LINK_W-1:0] next_free [SLOTS];
  logic [SLOTS-1:0]  link_valid;
  logic [LINK_W-1:0] rd_data;
  logic              rd_valid;

  logic [REM_W-1:0]  rem;
  logic [SLOT_W-1:0] quot;
  logic [CNT_W-1:0]  cnt;

  logic [1:0]        res_status;
  logic [SLOT_W-1:0] res_slot;
  logic [PAGE_W-1:0] res_page;

  logic [STR_W-1:0]  stride;
  logic [REM_W-1:0]  span;
  logic [PAGE_W:0]   diff;
  logic [REM_W-1:0]  trial;
  logic [SLOT_W-1:0] rd_idx;
  logic [SLOT_W-1:0] cur_slot;
  logic [LINK_W-1:0] link_eff;
  logic [PROD_W-1:0] prod;
  logic [PAGE_W-1:0] head_page;
  logic              wr_en;
  logic [LINK_W-1:0] wr_data;

  // stride = 2^order + 1 pages; area spans SLOTS strides less the last guard
  assign stride = (STR_W'(1) << slot_order) + STR_W'(1);
  assign span   = (REM_W'(stride) << SLOT_W) - REM_W'(1);
  assign diff   = {1'b0, addr} - {1'b0, area_base_page};
  assign trial  = REM_W'(stride) << cnt;

  assign rd_idx   = cmd.rd_quot ? quot : head_link[SLOT_W-1:0];
  assign cur_slot = (op == ACT_FREE) ? quot : head_link[SLOT_W-1:0];
  assign link_eff = rd_valid ? rd_data : reset_link(cur_slot);

  assign prod      = (PROD_W'(head_link[SLOT_W-1:0]) << slot_order)
                   + PROD_W'(head_link[SLOT_W-1:0]);
  assign head_page = area_base_page + PAGE_W'(prod);

  assign wr_en   = cmd.pop || cmd.push;
  assign wr_data = cmd.push ? head_link : END_MARK;

  assign sts.is_free    = (op == ACT_FREE);
  assign sts.head_empty = head_link[LINK_W-1];
  assign sts.out_range  = diff[PAGE_W] || (diff[PAGE_W-1:0] >= PAGE_W'(span));
  assign sts.div_last   = (cnt == '0);
  assign sts.marker_hit = (link_eff == END_MARK);

  // list memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      next_free[cur_slot] <= wr_data;
    end
    if (cmd.mem_rd) begin
      rd_data <= next_free[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_order     <= ORD_W'(1);
      area_base_page <= '0;
      head_link      <= LINK_W'(SLOTS - 1);
      free_slots     <= LINK_W'(SLOTS);
      link_valid     <= '0;
      rd_valid       <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_SLOT_ORDER: slot_order     <= cfg_data[ORD_W-1:0];
          CFG_AREA_BASE:  area_base_page <= cfg_data;
          default: begin
          end
        endcase
      end
      if (cmd.mem_rd) begin
        rd_valid <= link_valid[rd_idx];
      end
      if (wr_en) begin
        link_valid[cur_slot] <= 1'b1;
      end
      if (cmd.pop) begin
        head_link <= link_eff;
        if (free_slots != '0) begin
          free_slots <= free_slots - LINK_W'(1);
        end
      end else if (cmd.push) begin
        head_link <= {1'b0, quot};
        if (free_slots != LINK_W'(SLOTS)) begin
          free_slots <= free_slots + LINK_W'(1);
        end
      end
    end
  end

  // item, divider, result and output payload: no reset needed
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op   <= in_item.action;
      addr <= in_item.page_address;
    end
    if (cmd.div_init) begin
      rem  <= diff[REM_W-1:0];
      quot <= '0;
      cnt  <= CNT_W'(SLOT_W - 1);
    end else if (cmd.div_step) begin
      if (rem >= trial) begin
        rem       <= rem - trial;
        quot[cnt] <= 1'b1;
      end
      cnt <= cnt - CNT_W'(1);
    end
    if (cmd.pop) begin
      res_status <= ST_OK;
      res_slot   <= head_link[SLOT_W-1:0];
      res_page   <= head_page;
    end else if (cmd.push) begin
      res_status <= ST_OK;
      res_slot   <= quot;
      res_page   <= '0;
    end else if (cmd.set_err) begin
      res_status <= cmd.err_code;
      res_slot   <= '0;
      res_page   <= '0;
    end
    if (cmd.out_load) begin
      out_item.status     <= res_status;
      out_item.slot_index <= res_slot;
      out_item.slot_page  <= res_page;
      out_item.free_count <= free_slots;
      out_item.all_free   <= (free_slots == LINK_W'(SLOTS));
    end
  end

endmodule
